### rtl/dnslw_pkg.sv
// Package for the DNS name label walker: payload structs, status codes and defaults.
// Depends on nothing; used by the walker top level and its port checker.
package dnslw_pkg;

  // Default for the label limit after which a walk stops with the limit status.
  localparam int unsigned LW_MAX_LABELS_DEF = 128;

  localparam int unsigned LW_COUNT_W = 8;
  localparam int unsigned LW_OFFS_W  = 16;
  localparam int unsigned LW_START_W = 15;

  // Result status codes.
  localparam logic [1:0] LW_ST_DONE  = 2'd0;
  localparam logic [1:0] LW_ST_LIMIT = 2'd1;
  localparam logic [1:0] LW_ST_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  first;
    logic [LW_START_W-1:0] start_offset;
    logic                  last;
  } lw_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [LW_COUNT_W-1:0] label_count;
    logic [LW_OFFS_W-1:0]  last_label_offset;
    logic [LW_OFFS_W-1:0]  second_label_offset;
    logic [LW_OFFS_W-1:0]  third_label_offset;
  } lw_out_t;

endpackage

### rtl/dns_name_label_walker.sv
// DNS query-name label walker: top level with walk state, result register and skid entry.
// Depends on dnslw_pkg for the payload structs and status codes.
//
// Usage: the input channel carries one packet byte per transfer, starting at the
// first byte of a query name, which is marked with first and carries the name's
// packet offset. The walker follows the length-prefixed labels, counts them and
// tracks the offsets of the last three label length bytes. A walk ends on a zero
// length byte, when the label limit is reached and another byte exists, or when
// a byte marked last arrives first. Each walk yields one result transfer on the
// output channel. Bytes outside a walk are taken and dropped.
// A result is registered in the result register, or in the skid entry while the
// result register is held by a stall. Throughput: one byte per cycle while in_stall
// is low; the whole per-byte step is a few compares, two 16-bit adds and a counter
// update ahead of the state registers and the result register.
// When the receiver stalls, the result register holds its transfer and a single
// skid entry catches one more result; in_stall rises only while that skid entry
// is full, so input bytes keep flowing as long as no second result is pending.
// Reset (rst_n low, synchronous) empties the result register and skid entry and
// leaves the walker idle until the next byte marked first.
module dns_name_label_walker
  import dnslw_pkg::*;
#(
  parameter int unsigned MAX_LABELS = LW_MAX_LABELS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  lw_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output lw_out_t out_data
);

  localparam logic [LW_COUNT_W-1:0] MaxLbl = LW_COUNT_W'(MAX_LABELS);

  // Walk state.
  logic                  walking_r;
  logic [LW_OFFS_W-1:0]  byte_pos_r;
  logic [LW_OFFS_W-1:0]  next_len_pos_r;
  logic [LW_COUNT_W-1:0] labels_r;
  logic [LW_OFFS_W-1:0]  off0_r, off1_r, off2_r;

  // Output side: result register and one skid entry.
  logic    out_valid_r;
  lw_out_t out_data_r;
  logic    skid_valid_r;
  lw_out_t skid_data_r;

  logic                  accept;
  logic                  active;
  logic [LW_OFFS_W-1:0]  start16;
  logic [LW_OFFS_W-1:0]  pos, nlp;
  logic [LW_COUNT_W-1:0] cnt;
  logic [LW_OFFS_W-1:0]  o0, o1, o2;
  logic                  at_len, hit_limit, hit_zero, add_label, hit_trunc, emit;
  logic [LW_COUNT_W-1:0] labels_nxt;
  logic [LW_OFFS_W-1:0]  next_len_pos_nxt;
  logic [LW_OFFS_W-1:0]  off0_nxt, off1_nxt, off2_nxt;
  lw_out_t               result;
  logic                  drain;

  assign accept = in_valid && !in_stall;
  assign start16 = {1'b0, in_data.start_offset};

  // A byte marked first restarts the walk at its own offset, abandoning any walk
  // in progress without a result.
  always_comb begin
    active = in_data.first || walking_r;
    pos    = in_data.first ? start16 : byte_pos_r;
    nlp    = in_data.first ? start16 : next_len_pos_r;
    cnt    = in_data.first ? '0 : labels_r;
    o0     = in_data.first ? start16 : off0_r;
    o1     = in_data.first ? start16 : off1_r;
    o2     = in_data.first ? start16 : off2_r;

    // At a length byte the label limit wins over the value of the byte.
    at_len    = (pos == nlp);
    hit_limit = at_len && (cnt >= MaxLbl);
    hit_zero  = at_len && !hit_limit && (in_data.data_byte == 8'd0);
    add_label = at_len && !hit_limit && (in_data.data_byte != 8'd0);
    // The end of the packet only truncates when this byte did not end the walk;
    // a label whose length byte is the last byte is counted first.
    hit_trunc = in_data.last && !hit_limit && !hit_zero;
    emit      = active && (hit_limit || hit_zero || hit_trunc);

    labels_nxt       = add_label ? cnt + 8'd1 : cnt;
    next_len_pos_nxt = add_label ? pos + {8'd0, in_data.data_byte} + 16'd1 : nlp;
    off0_nxt         = add_label ? pos : o0;
    off1_nxt         = add_label ? o0 : o1;
    off2_nxt         = add_label ? o1 : o2;

    result.label_count         = labels_nxt;
    result.last_label_offset   = off0_nxt;
    result.second_label_offset = off1_nxt;
    result.third_label_offset  = off2_nxt;
    if (hit_limit) begin
      result.status = LW_ST_LIMIT;
    end else if (hit_zero) begin
      result.status = LW_ST_DONE;
    end else begin
      result.status = LW_ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r      <= 1'b0;
      byte_pos_r     <= '0;
      next_len_pos_r <= '0;
      labels_r       <= '0;
      off0_r         <= '0;
      off1_r         <= '0;
      off2_r         <= '0;
    end else if (accept && active) begin
      walking_r      <= !emit;
      byte_pos_r     <= pos + 16'd1;
      next_len_pos_r <= next_len_pos_nxt;
      labels_r       <= labels_nxt;
      off0_r         <= off0_nxt;
      off1_r         <= off1_nxt;
      off2_r         <= off2_nxt;
    end
  end

  // The skid entry only fills while the result register is held by a stall, and
  // it empties first, so results leave in order.
  assign drain = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (drain) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !drain) begin
      if (accept && emit) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= result;
      end
    end else begin
      out_valid_r <= accept && emit;
      out_data_r  <= result;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/dnslw_checker.sv
// Port checker for the DNS name label walker, bound to the top level.
// Depends on dnslw_pkg for the payload structs and status codes.
module dnslw_checker
  import dnslw_pkg::*;
#(
  parameter int unsigned MAX_LABELS = LW_MAX_LABELS_DEF
) (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input lw_in_t  in_data,
  input logic    out_valid,
  input logic    out_stall,
  input lw_out_t out_data
);

  // A held result stays put until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // The input side only backs up after the result side has been stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // Status codes stay within the defined set and counts within the limit.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= LW_ST_TRUNC &&
                  out_data.label_count <= LW_COUNT_W'(MAX_LABELS))
    else $error("result status or label count out of range");

  // A root name reports all three offsets equal.
  a_root_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == LW_ST_DONE && out_data.label_count == '0 |->
      out_data.last_label_offset == out_data.second_label_offset &&
      out_data.second_label_offset == out_data.third_label_offset)
    else $error("root name offsets differ");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall pending after reset");

endmodule

bind dns_name_label_walker dnslw_checker #(.MAX_LABELS(MAX_LABELS)) u_dnslw_checker (.*);
